// ===== design/rld_pkg.sv =====
// Shared constants and codes for the radial lens distortion remap block.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package rld_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FRAC_BITS  = 16;

    localparam logic [SIZE_W-1:0]        SIZE_RESET       = 9'd256;
    localparam logic signed [COEF_W-1:0] COEF_ZERO_RESET  = 16'sd0;
    localparam logic signed [COEF_W-1:0] COEF_FIRST_RESET = 16'sd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_COEF_FOURTH  = 3'd2,
        CFG_COEF_THIRD   = 3'd3,
        CFG_COEF_SECOND  = 3'd4,
        CFG_COEF_FIRST   = 3'd5
    } t_cfg_index;

endpackage

// ===== design/radial_lens_distortion_remap.sv =====
// Radial lens distortion remap: frame store, fixed-point remap pipeline, sampler.
// Depends on rld_pkg, rld_div_pipe and rld_sqrt_pipe.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): i_op = 0 writes a pixel
//    {i_in_chan2, i_in_chan1, i_in_chan0} at (i_col, i_row); i_op = 1 queries
//    the corrected output pixel at (i_col, i_row).
//  - Output channel (o_out_valid / i_out_ready): one transaction per query,
//    none per write, in input order. o_inside_res = 0 means the query or its
//    source lay outside the frame and the channels read zero.
//  - Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index
//    and data of frame size and radial coefficients; write only while idle.
//  - Throughput: one transaction per clock while o_in_ready is high. The path
//    to o_out_valid runs through the 18-stage offset dividers, the
//    18-stage square root and the 17-stage cosine and sine dividers in series,
//    plus the squaring, polynomial and displacement stages.
//  - The frame store is read or written once per transaction, at the address
//    stage of the pipeline.
//  - Reset clears the pipeline and restores the configuration defaults; the
//    frame store holds no defined contents until written.
//  - When the receiver stalls, the result register holds; the pipeline keeps
//    advancing while its last stage holds no query.
`timescale 1ns / 1ps

module radial_lens_distortion_remap
    import rld_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [POS_W-1:0]      i_col,
    input  logic [POS_W-1:0]      i_row,
    input  logic [PIX_W-1:0]      i_in_chan0,
    input  logic [PIX_W-1:0]      i_in_chan1,
    input  logic [PIX_W-1:0]      i_in_chan2,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_out_chan0,
    output logic [PIX_W-1:0]      o_out_chan1,
    output logic [PIX_W-1:0]      o_out_chan2,
    output logic                  o_inside_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(DEPTH);
    localparam int DEN_W    = SIZE_W + 1;
    localparam int XY_QW    = 18;
    localparam int RT_W     = 18;
    localparam int CS_QW    = 17;
    localparam int S_XY_OUT = 1 + XY_QW;
    localparam int S_XM     = S_XY_OUT + 1;
    localparam int S_SUM    = S_XM + 2;
    localparam int S_ROOT   = S_SUM + RT_W;
    localparam int S_CS_OUT = S_ROOT + CS_QW;
    localparam int S_CS     = S_CS_OUT + 1;
    localparam int S_P      = S_ROOT + 4;
    localparam int S_ADDR   = S_CS + 4;
    localparam int S_MEM    = S_ADDR + 1;
    localparam int PW       = 43;

    typedef struct packed {
        logic                 valid;
        logic                 op;
        logic                 hit;
        logic                 xs;
        logic                 ys;
        logic [AW-1:0]        addr;
        logic [3*PIX_W-1:0]   data;
    } t_side;

    // configuration
    logic [SIZE_W-1:0]        r_fw, r_fh;
    logic signed [COEF_W-1:0] r_c4, r_c3, r_c2, r_c1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= SIZE_RESET;
            r_fh <= SIZE_RESET;
            r_c4 <= COEF_ZERO_RESET;
            r_c3 <= COEF_ZERO_RESET;
            r_c2 <= COEF_ZERO_RESET;
            r_c1 <= COEF_FIRST_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data[SIZE_W-1:0];
                CFG_COEF_FOURTH:  r_c4 <= $signed(i_cfg_data);
                CFG_COEF_THIRD:   r_c3 <= $signed(i_cfg_data);
                CFG_COEF_SECOND:  r_c2 <= $signed(i_cfg_data);
                CFG_COEF_FIRST:   r_c1 <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    logic [SIZE_W-1:0] w_w, w_h, w_w1, w_h1;
    logic [DEN_W-1:0]  w_den;

    assign w_w   = (r_fw < 9'd2) ? 9'd2 :
                   ((32'(r_fw) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : r_fw);
    assign w_h   = (r_fh < 9'd2) ? 9'd2 :
                   ((32'(r_fh) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_fh);
    assign w_w1  = w_w - 9'd1;
    assign w_h1  = w_h - 9'd1;
    assign w_den = {1'b0, w_w} + {1'b0, w_h} - 10'd2;

    // handshake
    t_side r_side [1:S_MEM];
    logic  r_out_valid;
    logic  w_en;

    assign w_en       = !(r_out_valid && !i_out_ready && r_side[S_MEM].valid &&
                          r_side[S_MEM].op);
    assign o_in_ready = w_en;

    // accept stage
    logic signed [11:0] w_nx, w_ny;
    logic [9:0]         w_mx_in, w_my_in;
    t_side              w_side_in;
    logic               w_wr_ok, w_q_ok;

    assign w_nx    = $signed({2'b0, i_col, 2'b0}) - $signed({2'b0, w_w1, 1'b0});
    assign w_ny    = $signed({2'b0, i_row, 2'b0}) - $signed({2'b0, w_h1, 1'b0});
    assign w_mx_in = w_nx[11] ? 10'(-w_nx) : w_nx[9:0];
    assign w_my_in = w_ny[11] ? 10'(-w_ny) : w_ny[9:0];
    assign w_wr_ok = (32'(i_col) < MAX_WIDTH) && (32'(i_row) < MAX_HEIGHT);
    assign w_q_ok  = ({1'b0, i_col} < w_w) && ({1'b0, i_row} < w_h);

    always_comb begin
        w_side_in.valid = i_in_valid;
        w_side_in.op    = i_op;
        w_side_in.hit   = i_op ? w_q_ok : w_wr_ok;
        w_side_in.xs    = w_nx[11];
        w_side_in.ys    = w_ny[11];
        w_side_in.addr  = AW'(32'(i_row) * MAX_WIDTH) + AW'(i_col);
        w_side_in.data  = {i_in_chan2, i_in_chan1, i_in_chan0};
    end

    logic [DEN_W+XY_QW-1:0] r_nx_num, r_ny_num;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx_num <= {2'b0, w_mx_in, 16'b0};
            r_ny_num <= {2'b0, w_my_in, 16'b0};
        end
    end

    // normalised offsets
    logic [XY_QW-1:0] w_qx, w_qy;
    logic             w_nzx, w_nzy;

    rld_div_pipe #(.DW(DEN_W), .QW(XY_QW)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_nx_num), .i_den(w_den),
        .o_quot(w_qx), .o_rem_nz(w_nzx)
    );

    rld_div_pipe #(.DW(DEN_W), .QW(XY_QW)) u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_ny_num), .i_den(w_den),
        .o_quot(w_qy), .o_rem_nz(w_nzy)
    );

    logic [XY_QW-1:0] r_xm, r_ym;
    logic [2*RT_W-1:0] r_sqx, r_sqy, r_sum;
    logic [XY_QW-1:0] r_xmd [S_ROOT-S_XM];
    logic [XY_QW-1:0] r_ymd [S_ROOT-S_XM];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xm  <= w_qx + XY_QW'(r_side[S_XY_OUT].xs & w_nzx);
            r_ym  <= w_qy + XY_QW'(r_side[S_XY_OUT].ys & w_nzy);
            r_sqx <= r_xm * r_xm;
            r_sqy <= r_ym * r_ym;
            r_sum <= r_sqx + r_sqy;
            r_xmd[0] <= r_xm;
            r_ymd[0] <= r_ym;
            for (int k = 1; k < S_ROOT - S_XM; k++) begin
                r_xmd[k] <= r_xmd[k-1];
                r_ymd[k] <= r_ymd[k-1];
            end
        end
    end

    // radius
    logic [RT_W-1:0] w_root;

    rld_sqrt_pipe #(.OW(RT_W)) u_sqrt (
        .i_clk(i_clk), .i_en(w_en), .i_val(r_sum), .o_root(w_root)
    );

    // cosine and sine magnitudes
    logic [CS_QW-1:0] w_qc, w_qs;
    logic             w_nzc, w_nzs;

    rld_div_pipe #(.DW(RT_W), .QW(CS_QW)) u_div_c (
        .i_clk(i_clk), .i_en(w_en),
        .i_num({1'b0, r_xmd[S_ROOT-S_XM-1], 16'b0}), .i_den(w_root),
        .o_quot(w_qc), .o_rem_nz(w_nzc)
    );

    rld_div_pipe #(.DW(RT_W), .QW(CS_QW)) u_div_s (
        .i_clk(i_clk), .i_en(w_en),
        .i_num({1'b0, r_ymd[S_ROOT-S_XM-1], 16'b0}), .i_den(w_root),
        .o_quot(w_qs), .o_rem_nz(w_nzs)
    );

    logic                   r_rz [S_CS_OUT-S_ROOT];
    logic signed [CS_QW:0]  r_cs, r_sn;
    logic [CS_QW-1:0]       w_cm, w_sm;

    assign w_cm = w_qc + CS_QW'(r_side[S_CS_OUT].xs & w_nzc);
    assign w_sm = w_qs + CS_QW'(r_side[S_CS_OUT].ys & w_nzs);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rz[0] <= (w_root == '0);
            for (int k = 1; k < S_CS_OUT - S_ROOT; k++) begin
                r_rz[k] <= r_rz[k-1];
            end
            if (r_rz[S_CS_OUT-S_ROOT-1]) begin
                r_cs <= 18'sd65536;
                r_sn <= 18'sd0;
            end else begin
                r_cs <= r_side[S_CS_OUT].xs ? -$signed({1'b0, w_cm}) : $signed({1'b0, w_cm});
                r_sn <= r_side[S_CS_OUT].ys ? -$signed({1'b0, w_sm}) : $signed({1'b0, w_sm});
            end
        end
    end

    // radial polynomial
    logic [2*RT_W-1:0]       w_rr;
    logic [37:0]             w_p3;
    logic [39:0]             w_p4;
    logic [19:0]             r_r2, r_r2b;
    logic [RT_W-1:0]         r_r1, r_r1b;
    logic [21:0]             r_r3;
    logic [23:0]             r_r4;
    logic signed [40:0]      r_m4, r_m3, r_m2, r_m1;
    logic signed [PW-1:0]    r_p;
    logic signed [PW-1:0]    r_pd [S_CS-S_P];

    assign w_rr = w_root * w_root;
    assign w_p3 = r_r2 * r_r1;
    assign w_p4 = r_r2 * r_r2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2  <= w_rr[35:16];
            r_r1  <= w_root;
            r_r3  <= w_p3[37:16];
            r_r4  <= w_p4[39:16];
            r_r2b <= r_r2;
            r_r1b <= r_r1;
            r_m4  <= r_c4 * $signed({1'b0, r_r4});
            r_m3  <= r_c3 * $signed({1'b0, r_r3});
            r_m2  <= r_c2 * $signed({1'b0, r_r2b});
            r_m1  <= r_c1 * $signed({1'b0, r_r1b});
            r_p   <= PW'(r_m4) + PW'(r_m3) + PW'(r_m2) + PW'(r_m1);
            r_pd[0] <= r_p;
            for (int k = 1; k < S_CS - S_P; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    // displacement
    logic signed [39:0] r_ppx_lo, r_ppx_hi, r_ppy_lo, r_ppy_hi;
    logic signed [60:0] w_prodx, w_prody;
    logic signed [32:0] r_qxv, r_qyv;
    logic signed [43:0] r_dmx, r_dmy;
    logic signed [PW-1:0] w_pf;

    assign w_pf    = r_pd[S_CS-S_P-1];
    assign w_prodx = (61'(r_ppx_hi) <<< 21) + 61'(r_ppx_lo);
    assign w_prody = (61'(r_ppy_hi) <<< 21) + 61'(r_ppy_lo);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ppx_lo <= $signed({1'b0, w_pf[20:0]}) * r_cs;
            r_ppx_hi <= $signed(w_pf[PW-1:21]) * r_cs;
            r_ppy_lo <= $signed({1'b0, w_pf[20:0]}) * r_sn;
            r_ppy_hi <= $signed(w_pf[PW-1:21]) * r_sn;
            r_qxv    <= $signed(w_prodx[60:28]);
            r_qyv    <= $signed(w_prody[60:28]);
            r_dmx    <= r_qxv * $signed({1'b0, w_den});
            r_dmy    <= r_qyv * $signed({1'b0, w_den});
        end
    end

    // source coordinate and bounds
    logic signed [42:0] w_tx, w_ty;
    logic               w_in_x, w_in_y;
    logic [AW-1:0]      w_qaddr;
    t_side              w_side_adr;

    assign w_tx   = 43'($signed({1'b0, w_w1, 15'b0})) + 43'($signed(r_dmx[43:2]));
    assign w_ty   = 43'($signed({1'b0, w_h1, 15'b0})) + 43'($signed(r_dmy[43:2]));
    assign w_in_x = !w_tx[42] && (w_tx < 43'($signed({1'b0, w_w1, 16'b0})));
    assign w_in_y = !w_ty[42] && (w_ty < 43'($signed({1'b0, w_h1, 16'b0})));
    assign w_qaddr = AW'(32'(w_ty[24:16]) * MAX_WIDTH) + AW'(w_tx[24:16]);

    always_comb begin
        w_side_adr = r_side[S_ADDR-1];
        if (r_side[S_ADDR-1].op) begin
            w_side_adr.hit  = r_side[S_ADDR-1].hit && w_in_x && w_in_y;
            w_side_adr.addr = w_qaddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= S_MEM; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side[1] <= w_side_in;
            for (int k = 2; k <= S_MEM; k++) begin
                r_side[k] <= (k == S_ADDR) ? w_side_adr : r_side[k-1];
            end
        end
    end

    // frame store
    logic [3*PIX_W-1:0] r_mem [DEPTH];
    logic [3*PIX_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_side[S_ADDR].valid && !r_side[S_ADDR].op && r_side[S_ADDR].hit) begin
                r_mem[r_side[S_ADDR].addr] <= r_side[S_ADDR].data;
            end
            r_rd <= r_mem[r_side[S_ADDR].addr];
        end
    end

    // result register
    logic [PIX_W-1:0] r_out_c0, r_out_c1, r_out_c2;
    logic             r_out_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_side[S_MEM].valid && r_side[S_MEM].op && w_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out_in <= r_side[S_MEM].hit;
            r_out_c0 <= r_side[S_MEM].hit ? r_rd[PIX_W-1:0]         : '0;
            r_out_c1 <= r_side[S_MEM].hit ? r_rd[2*PIX_W-1:PIX_W]   : '0;
            r_out_c2 <= r_side[S_MEM].hit ? r_rd[3*PIX_W-1:2*PIX_W] : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_chan0  = r_out_c0;
    assign o_out_chan1  = r_out_c1;
    assign o_out_chan2  = r_out_c2;
    assign o_inside_res = r_out_in;

endmodule

// ===== design/rld_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Stand-alone; used by the radial lens distortion remap top level.
`timescale 1ns / 1ps

module rld_div_pipe #(
    parameter int DW = 10,
    parameter int QW = 18
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [QW-1:0]    o_quot,
    output logic             o_rem_nz
);

    localparam int RW = DW + QW;

    logic [RW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam logic [QW-1:0] QBIT = QW'(1) << (QW - 1 - k);
            logic [RW-1:0] w_rem_in;
            logic [DW-1:0] w_den_in;
            logic [QW-1:0] w_quo_in;
            logic [RW-1:0] w_trial;

            if (k == 0) begin : g_first
                assign w_rem_in = i_num;
                assign w_den_in = i_den;
                assign w_quo_in = '0;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_den_in = r_den[k-1];
                assign w_quo_in = r_quo[k-1];
            end

            assign w_trial = RW'(w_den_in) << (QW - 1 - k);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= w_den_in;
                    if (w_rem_in >= w_trial) begin
                        r_rem[k] <= w_rem_in - w_trial;
                        r_quo[k] <= w_quo_in | QBIT;
                    end else begin
                        r_rem[k] <= w_rem_in;
                        r_quo[k] <= w_quo_in;
                    end
                end
            end
        end
    endgenerate

    assign o_quot   = r_quo[QW-1];
    assign o_rem_nz = |r_rem[QW-1];

endmodule

// ===== design/rld_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per stage (floor result).
// Stand-alone; used by the radial lens distortion remap top level.
`timescale 1ns / 1ps

module rld_sqrt_pipe #(
    parameter int OW = 18
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*OW-1:0] i_val,
    output logic [OW-1:0]   o_root
);

    localparam int RW = OW + 3;

    logic [RW-1:0]   r_rem  [OW];
    logic [OW-1:0]   r_root [OW];
    logic [2*OW-1:0] r_val  [OW];

    genvar k;
    generate
        for (k = 0; k < OW; k++) begin : g_stage
            logic [RW-1:0]   w_rem_in;
            logic [OW-1:0]   w_root_in;
            logic [2*OW-1:0] w_val_in;
            logic [RW-1:0]   w_cur;
            logic [RW-1:0]   w_trial;

            if (k == 0) begin : g_first
                assign w_rem_in  = '0;
                assign w_root_in = '0;
                assign w_val_in  = i_val;
            end else begin : g_next
                assign w_rem_in  = r_rem[k-1];
                assign w_root_in = r_root[k-1];
                assign w_val_in  = r_val[k-1];
            end

            assign w_cur   = {w_rem_in[RW-3:0], w_val_in[2*OW-1 -: 2]};
            assign w_trial = RW'({w_root_in, 2'b01});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_val[k] <= w_val_in << 2;
                    if (w_cur >= w_trial) begin
                        r_rem[k]  <= w_cur - w_trial;
                        r_root[k] <= {w_root_in[OW-2:0], 1'b1};
                    end else begin
                        r_rem[k]  <= w_cur;
                        r_root[k] <= {w_root_in[OW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[OW-1];

endmodule

// ===== design/rld_checker.sv =====
// Port-level assertions for the radial lens distortion remap top level.
// Depends on rld_pkg; bound to radial_lens_distortion_remap below.
`timescale 1ns / 1ps

module rld_checker
    import rld_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PIX_W-1:0]      o_out_chan0,
    input logic [PIX_W-1:0]      o_out_chan1,
    input logic [PIX_W-1:0]      o_out_chan2,
    input logic                  o_inside_res
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_chan0) && $stable(o_out_chan1) &&
            $stable(o_out_chan2) && $stable(o_inside_res))
        else $error("stalled result changed");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_inside_res |->
            o_out_chan0 == '0 && o_out_chan1 == '0 && o_out_chan2 == '0)
        else $error("outside result carries pixel data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind radial_lens_distortion_remap rld_checker u_rld_checker (.*);
